>>> rtl/hcbp_pkg.sv
package hcbp_pkg;

	// transaction codes on the opcode field
	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_ENCODE = 2'd1,
		OP_FLUSH  = 2'd2
	} op_t;

	// fixed field widths
	localparam int OP_W      = 2;
	localparam int SYM_W     = 8;
	localparam int CODE_W    = 32;
	localparam int LEN_W     = 6;
	localparam int BYTE_W    = 8;
	localparam int PAD_W     = 3;
	localparam int PEND_W    = 7;
	localparam int CNT_W     = 3;
	localparam int TOTAL_W   = 6;
	localparam int ACC_W     = PEND_W + CODE_W;
	localparam int SLOTS     = 4;
	localparam int SLOT_W    = 3;
	localparam int EMIT_W    = SLOTS * BYTE_W;

	// parameter defaults
	localparam int SYMBOLS_DEF      = 256;
	localparam int MAX_CODE_LEN_DEF = 32;

endpackage

>>> rtl/huffman_code_bit_packer.sv
// Huffman code bit packer.
// Input channel (item_valid / item_ready) carries one transaction per item:
// a table load (symbol, code_bits right aligned, code_length), a symbol
// encode, or a flush. Loads write the code table and give no result.
// Encodes append the symbol's code MSB first to a bit accumulator and give
// one result per byte completed (zero to four). A flush gives exactly one
// result: the remaining bits padded with zeros on the right, or an empty
// result with byte_valid low when nothing is pending.
// Output channel (result_valid / result_ready) carries out_byte, byte_valid,
// pad_bits and is_last, the last marking the final result of an item.
// The edge that accepts an item loads the read stage; the output register loads
// when the read stage moves on, and the first result is then offered.
// Throughput: one item per cycle while each item gives at most one result and
// the receiver takes it; an encode that completes more than one byte holds the
// output register until all are taken, as the output port is single-byte. Items
// giving no result pass the output register even while it is stalled.
// Reset clears the accumulator, the pipeline and every table valid bit, so
// the whole table reads as length zero at once with no clearing sweep.
// When the receiver stalls, the result holds and the input side fills one
// stage before item_ready falls.
module huffman_code_bit_packer
	import hcbp_pkg::*;
#(
	parameter int SYMBOLS      = SYMBOLS_DEF,
	parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  logic [OP_W-1:0]     opcode,
	input  logic [SYM_W-1:0]    symbol,
	input  logic [CODE_W-1:0]   code_bits,
	input  logic [LEN_W-1:0]    code_length,
	output logic                result_valid,
	input  logic                result_ready,
	output logic [BYTE_W-1:0]   out_byte,
	output logic                byte_valid,
	output logic [PAD_W-1:0]    pad_bits,
	output logic                is_last
);

	localparam int LenCap  = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
	localparam int LenW    = $clog2(LenCap + 1);
	localparam int IdxW    = $clog2(SYMBOLS);
	localparam int EntryW  = LenCap + LenW;

	// handshake
	logic item_fire;
	logic out_fire;
	logic emit_free;
	logic s1_move;

	// load path
	logic [IdxW-1:0]   idx;
	logic              in_range;
	logic              wr_en;
	logic [LEN_W-1:0]  len_sat;
	logic [CODE_W-1:0] code_mask;
	logic [CODE_W-1:0] code_clip;

	// table storage
	logic [EntryW-1:0] tbl_mem [SYMBOLS];
	logic              tbl_vld_q [SYMBOLS];

	// read stage
	logic              vld_s1;
	logic [OP_W-1:0]   op_s1;
	logic              inrng_s1;
	logic              tvld_s1;
	logic [EntryW-1:0] entry_s1;

	// accumulator state
	logic [PEND_W-1:0] pend_bits_q;
	logic [CNT_W-1:0]  pend_cnt_q;

	// packing logic
	logic [LEN_W-1:0]   len_e;
	logic [CODE_W-1:0]  code_e;
	logic [ACC_W-1:0]   acc;
	logic [ACC_W-1:0]   acc_aligned;
	logic [TOTAL_W-1:0] total;
	logic [2:0]         rem;
	logic [5:0]         lsh;
	logic [SLOT_W-1:0]  pk_n;
	logic [EMIT_W-1:0]  pk_data;
	logic               pk_bv;
	logic [PAD_W-1:0]   pk_pad;
	logic               pk_upd;
	logic [PEND_W-1:0]  pk_pend;
	logic [CNT_W-1:0]   pk_cnt;

	// output register
	logic [EMIT_W-1:0] emit_data_q;
	logic [SLOT_W-1:0] emit_cnt_q;
	logic              emit_bv_q;
	logic [PAD_W-1:0]  emit_pad_q;

	// flow control
	assign out_fire   = result_valid && result_ready;
	assign emit_free  = (emit_cnt_q == '0) || ((emit_cnt_q == SLOT_W'(1)) && result_ready);
	assign s1_move    = vld_s1 && ((pk_n == '0) || emit_free);
	assign item_ready = !vld_s1 || s1_move;
	assign item_fire  = item_valid && item_ready;

	// table load: saturate length, drop code bits above it
	assign idx      = symbol[IdxW-1:0];
	assign in_range = ({1'b0, symbol} < (SYM_W + 1)'(SYMBOLS));
	assign wr_en    = item_fire && (opcode == OP_LOAD) && in_range;
	assign len_sat  = (code_length > LEN_W'(LenCap)) ? LEN_W'(LenCap) : code_length;
	assign code_mask = (len_sat >= LEN_W'(CODE_W)) ? '1 : ~({CODE_W{1'b1}} << len_sat);
	assign code_clip = code_bits & code_mask;

	// table memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			tbl_mem[idx] <= {LenW'(len_sat), LenCap'(code_clip)};
		end
		if (item_fire) begin
			entry_s1 <= tbl_mem[idx];
		end
	end

	// per-entry valid bits, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SYMBOLS; i++) begin
				tbl_vld_q[i] <= 1'b0;
			end
		end else if (wr_en) begin
			tbl_vld_q[idx] <= 1'b1;
		end
	end

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item_ready) begin
			vld_s1 <= item_valid;
		end
	end

	// read stage payload
	always_ff @(posedge clk) begin
		if (item_fire) begin
			op_s1    <= opcode;
			inrng_s1 <= in_range;
			tvld_s1  <= tbl_vld_q[idx];
		end
	end

	// append code to pending bits and split off whole bytes
	assign len_e  = tvld_s1 ? LEN_W'(entry_s1[EntryW-1 -: LenW]) : '0;
	assign code_e = tvld_s1 ? CODE_W'(entry_s1[LenCap-1:0]) : '0;
	assign acc    = (ACC_W'(pend_bits_q) << len_e) | ACC_W'(code_e);
	assign total  = TOTAL_W'(pend_cnt_q) + TOTAL_W'(len_e);
	assign rem    = total[2:0];
	assign acc_aligned = acc >> rem;
	assign lsh    = {3'(3'd4 - total[5:3]), 3'b000};

	// result and accumulator update per transaction type
	always_comb begin
		pk_n    = '0;
		pk_data = '0;
		pk_bv   = 1'b0;
		pk_pad  = '0;
		pk_upd  = 1'b0;
		pk_pend = '0;
		pk_cnt  = '0;
		case (op_s1)
			OP_ENCODE: begin
				if (inrng_s1) begin
					pk_n    = total[5:3];
					pk_data = EMIT_W'(acc_aligned) << lsh;
					pk_bv   = 1'b1;
					pk_upd  = 1'b1;
					pk_pend = acc[PEND_W-1:0] & PEND_W'((8'd1 << rem) - 8'd1);
					pk_cnt  = rem;
				end
			end
			OP_FLUSH: begin
				pk_n   = SLOT_W'(1);
				pk_upd = 1'b1;
				if (pend_cnt_q != '0) begin
					pk_data = {BYTE_W'({1'b0, pend_bits_q} << (4'd8 - 4'(pend_cnt_q))),
						{(EMIT_W - BYTE_W){1'b0}}};
					pk_bv   = 1'b1;
					pk_pad  = PAD_W'(4'd8 - 4'(pend_cnt_q));
				end
			end
			default: begin
				pk_n = '0;
			end
		endcase
	end

	// pending bit accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
		end else if (s1_move && pk_upd) begin
			pend_bits_q <= pk_pend;
			pend_cnt_q  <= pk_cnt;
		end
	end

	// output register: byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_cnt_q <= '0;
		end else if (s1_move && (pk_n != '0)) begin
			emit_cnt_q <= pk_n;
		end else if (out_fire) begin
			emit_cnt_q <= emit_cnt_q - SLOT_W'(1);
		end
	end

	// output register: bytes, first one at the top
	always_ff @(posedge clk) begin
		if (s1_move && (pk_n != '0)) begin
			emit_data_q <= pk_data;
			emit_bv_q   <= pk_bv;
			emit_pad_q  <= pk_pad;
		end else if (out_fire) begin
			emit_data_q <= emit_data_q << BYTE_W;
		end
	end

	// result ports
	assign result_valid = (emit_cnt_q != '0);
	assign out_byte     = emit_data_q[EMIT_W-1 -: BYTE_W];
	assign byte_valid   = emit_bv_q;
	assign pad_bits     = emit_pad_q;
	assign is_last      = (emit_cnt_q == SLOT_W'(1));

endmodule

>>> rtl/hcbp_checker.sv
module hcbp_checker
	import hcbp_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_ready,
	input logic [BYTE_W-1:0] out_byte,
	input logic              byte_valid,
	input logic [PAD_W-1:0]  pad_bits,
	input logic              is_last
);

	// nothing offered while reset is applied
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !result_valid)
		else $error("result offered during reset");

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(out_byte) && $stable(byte_valid) &&
			$stable(pad_bits) && $stable(is_last))
		else $error("stalled result changed");

	// padding only on the closing byte of a flush
	a_pad_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (pad_bits != '0) |-> byte_valid && is_last)
		else $error("padding on a non-final result");

	// an empty flush result carries nothing
	a_empty_flush: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !byte_valid |-> is_last && (pad_bits == '0) && (out_byte == '0))
		else $error("empty result with data");

	// after a non-final byte another result of the same item follows
	a_burst_cont: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !is_last |=> result_valid)
		else $error("byte burst broken");

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.out_byte     (out_byte),
	.byte_valid   (byte_valid),
	.pad_bits     (pad_bits),
	.is_last      (is_last)
);
